[hw/rtl/wildcard_substring_append_filter_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard substring append filter
// Shared property forms on clk with asynchronous active-low reset arst_n.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_SUBSTRING_APPEND_FILTER_TOP_MACROS_SVH
`define WILDCARD_SUBSTRING_APPEND_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define WSAF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wsaf: same-cycle check failed");

// next-cycle implication
`define WSAF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsaf: next-cycle check failed");

`endif

[hw/rtl/wsaf_pkg.sv]
// ----------------------------------------------------------------------------
// wsaf_pkg
// Types and constants shared by the filter controller, datapath and top.
// ----------------------------------------------------------------------------
package wsaf_pkg;

	localparam int TEXT_DEPTH_DEF    = 4096;
	localparam int PATTERN_DEPTH_DEF = 16;

	localparam int CHAR_W   = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [CHAR_W-1:0] WILDCARD_RST  = 8'd46;
	localparam logic [CHAR_W-1:0] SEPARATOR_RST = 8'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WILDCARD  = 1'b0,
		CFG_SEPARATOR = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK,
		ST_RD,
		ST_CMP,
		ST_DECIDE,
		ST_ARD,
		ST_AWR,
		ST_SEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic pat_wr;
		logic srch_init;
		logic k_inc;
		logic next_start;
		logic set_found;
		logic set_room_ovf;
		logic app_init;
		logic wr_pat;
		logic wr_sep;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic plen_gt_tlen;
		logic match;
		logic k_last;
		logic start_last;
		logic hit;
		logic pat_ovf;
		logic fits;
		logic out_busy;
	} sts_t;

endpackage

[hw/rtl/wildcard_substring_append_filter_top.sv]
// Sequence: a character without the last mark is stored in IDLE; a last character runs CHK,
// an RD/CMP pair per character compare in the search, DECIDE, an ARD/AWR pair per pattern
// character and SEP when appended, then DONE; no new input is taken until back in IDLE.
// Each compare reads through the registered read ports of the text and pattern memories.
// Reset: arst_n empties the text and pattern and restores wildcard '.' and separator LF.
// ----------------------------------------------------------------------------
// wildcard_substring_append_filter_top
// Collects patterns, searches the text with wildcards, appends misses to the text.
// ----------------------------------------------------------------------------
module wildcard_substring_append_filter_top #(
	parameter int TEXT_DEPTH    = wsaf_pkg::TEXT_DEPTH_DEF,
	parameter int PATTERN_DEPTH = wsaf_pkg::PATTERN_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wsaf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wsaf_pkg::CHAR_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [wsaf_pkg::CHAR_W-1:0]    char_in,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic                           appended,
	output logic                           overflow
);
	import wsaf_pkg::*;

	`include "wildcard_substring_append_filter_top_macros.svh"

	cmd_t cmd;
	sts_t sts;

	wsaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	wsaf_dp #(
		.TEXT_DEPTH    (TEXT_DEPTH),
		.PATTERN_DEPTH (PATTERN_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.char_in   (char_in),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.appended  (appended),
		.overflow  (overflow)
	);

	// a last-character transfer starts the search and blocks new input
	`WSAF_ASSERT_NEXT(a_search_blocks_input, in_valid && in_ready && last, !in_ready)
	`WSAF_ASSERT_NOW(a_found_not_appended, out_valid, !(found && appended))
	`WSAF_ASSERT_NOW(a_appended_no_overflow, out_valid && appended, !overflow)

endmodule

[hw/rtl/wsaf_ctrl.sv]
// ----------------------------------------------------------------------------
// wsaf_ctrl
// Sequencer for pattern capture, text search, append and result handoff.
// ----------------------------------------------------------------------------
module wsaf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last,
	output logic          in_ready,
	output wsaf_pkg::cmd_t cmd,
	input  wsaf_pkg::sts_t sts
);
	import wsaf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && last) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = sts.plen_gt_tlen ? ST_DECIDE : ST_RD;
			end
			ST_RD: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (sts.match && sts.k_last) begin
					state_d = ST_DECIDE;
				end else if (!sts.match && sts.start_last) begin
					state_d = ST_DECIDE;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_DECIDE: begin
				if (!sts.hit && !sts.pat_ovf && sts.fits) begin
					state_d = ST_ARD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_ARD: begin
				state_d = ST_AWR;
			end
			ST_AWR: begin
				state_d = sts.k_last ? ST_SEP : ST_ARD;
			end
			ST_SEP: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.pat_wr    = in_valid;
				cmd.srch_init = in_valid && last;
			end
			ST_CMP: begin
				cmd.set_found  = sts.match && sts.k_last;
				cmd.k_inc      = sts.match && !sts.k_last;
				cmd.next_start = !sts.match && !sts.start_last;
			end
			ST_DECIDE: begin
				cmd.app_init     = !sts.hit && !sts.pat_ovf && sts.fits;
				cmd.set_room_ovf = !sts.hit && !sts.pat_ovf && !sts.fits;
			end
			ST_AWR: begin
				cmd.wr_pat = 1'b1;
				cmd.k_inc  = 1'b1;
			end
			ST_SEP: begin
				cmd.wr_sep = 1'b1;
			end
			ST_DONE: begin
				cmd.res_load = !sts.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[hw/rtl/wsaf_dp.sv]
// ----------------------------------------------------------------------------
// wsaf_dp
// Text and pattern stores, search counters, config registers, result register.
// ----------------------------------------------------------------------------
module wsaf_dp #(
	parameter int TEXT_DEPTH    = wsaf_pkg::TEXT_DEPTH_DEF,
	parameter int PATTERN_DEPTH = wsaf_pkg::PATTERN_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wsaf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wsaf_pkg::CHAR_W-1:0]  cfg_data,
	input  logic [wsaf_pkg::CHAR_W-1:0]  char_in,
	input  wsaf_pkg::cmd_t               cmd,
	output wsaf_pkg::sts_t               sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic                         appended,
	output logic                         overflow
);
	import wsaf_pkg::*;

	localparam int AW  = $clog2(TEXT_DEPTH);
	localparam int TLW = $clog2(TEXT_DEPTH + 1);
	localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int PLW = $clog2(PATTERN_DEPTH + 1);
	localparam int SW  = ((TLW > PLW) ? TLW : PLW) + 1;

	logic [CHAR_W-1:0] text_mem [TEXT_DEPTH];
	logic [CHAR_W-1:0] pat_mem  [PATTERN_DEPTH];

	logic [CHAR_W-1:0] wild_q, sep_q;
	logic [CHAR_W-1:0] text_rd_q, pat_rd_q;
	logic [TLW-1:0]    tlen_q, start_q;
	logic [PLW-1:0]    plen_q, k_q;
	logic              povf_q, found_q, rovf_q, app_q;
	logic              out_valid_q, out_found_q, out_app_q, out_ovf_q;

	logic [SW-1:0]     plen_x, tlen_x, k_x, start_x;
	logic [AW-1:0]     text_raddr, text_waddr;
	logic              text_we;
	logic [CHAR_W-1:0] text_wdata;
	logic              pat_room;

	assign plen_x  = SW'(plen_q);
	assign tlen_x  = SW'(tlen_q);
	assign k_x     = SW'(k_q);
	assign start_x = SW'(start_q);

	assign pat_room = (plen_q < PLW'(PATTERN_DEPTH));

	// text address of the character under compare
	assign text_raddr = AW'(start_x + k_x);
	assign text_waddr = cmd.wr_sep ? AW'(tlen_x + plen_x) : AW'(tlen_x + k_x);
	assign text_we    = cmd.wr_pat || cmd.wr_sep;
	assign text_wdata = cmd.wr_sep ? sep_q : pat_rd_q;

	always_ff @(posedge clk) begin
		if (text_we) begin
			text_mem[text_waddr] <= text_wdata;
		end
		text_rd_q <= text_mem[text_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.pat_wr && pat_room) begin
			pat_mem[plen_q[PAW-1:0]] <= char_in;
		end
		pat_rd_q <= pat_mem[k_q[PAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wild_q <= WILDCARD_RST;
			sep_q  <= SEPARATOR_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WILDCARD:  wild_q <= cfg_data;
				CFG_SEPARATOR: sep_q  <= cfg_data;
				default: begin
					wild_q <= wild_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q  <= '0;
			plen_q  <= '0;
			povf_q  <= 1'b0;
			start_q <= '0;
			k_q     <= '0;
			found_q <= 1'b0;
			rovf_q  <= 1'b0;
			app_q   <= 1'b0;
		end else begin
			if (cmd.pat_wr) begin
				if (pat_room) begin
					plen_q <= plen_q + PLW'(1);
				end else begin
					povf_q <= 1'b1;
				end
			end
			if (cmd.srch_init) begin
				start_q <= '0;
				k_q     <= '0;
				found_q <= 1'b0;
				rovf_q  <= 1'b0;
				app_q   <= 1'b0;
			end
			if (cmd.k_inc) begin
				k_q <= k_q + PLW'(1);
			end
			// slide the window one place and restart the compare
			if (cmd.next_start) begin
				start_q <= start_q + TLW'(1);
				k_q     <= '0;
			end
			if (cmd.set_found) begin
				found_q <= 1'b1;
			end
			if (cmd.set_room_ovf) begin
				rovf_q <= 1'b1;
			end
			if (cmd.app_init) begin
				k_q <= '0;
			end
			if (cmd.wr_sep) begin
				tlen_q <= TLW'(tlen_x + plen_x + SW'(1));
				app_q  <= 1'b1;
			end
			if (cmd.res_load) begin
				plen_q <= '0;
				povf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_found_q <= found_q;
			out_app_q   <= app_q;
			out_ovf_q   <= povf_q || rovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = out_found_q;
	assign appended  = out_app_q;
	assign overflow  = out_ovf_q;

	assign sts.plen_gt_tlen = (plen_x > tlen_x);
	assign sts.match        = (pat_rd_q == wild_q) || (pat_rd_q == text_rd_q);
	assign sts.k_last       = ((k_x + SW'(1)) == plen_x);
	assign sts.start_last   = ((start_x + plen_x) == tlen_x);
	assign sts.hit          = found_q;
	assign sts.pat_ovf      = povf_q;
	assign sts.fits         = ((tlen_x + plen_x + SW'(1)) <= SW'(TEXT_DEPTH));
	assign sts.out_busy     = out_valid_q && !out_ready;

endmodule
